// ===== rtl/core/graph_merge_segmenter_core_defines.svh =====
// Assertion macros shared by the segmenter core.
`ifndef GRAPH_MERGE_SEGMENTER_CORE_DEFINES_SVH
`define GRAPH_MERGE_SEGMENTER_CORE_DEFINES_SVH

// plain invariant, checked at every clock edge out of reset
`define GMS_ASSERT_ALWAYS(name, expr, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) else $error(msg);

// same-cycle implication
`define GMS_ASSERT_IMPLY(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/gms_pkg.sv =====
// Types, codes and default constants of the graph merge segmenter.
package gms_pkg;

   localparam int MAX_PIXELS_DEF = 4096;
   localparam int MAX_EDGES_DEF  = 8192;

   localparam int PIX_FIELD_W = 12;
   localparam int WEIGHT_W    = 16;
   localparam int SIZE_FIELD_W = 13;
   localparam int THR_W       = 17;
   localparam int CMP_W       = 18;
   localparam int CSR_DATA_W  = 16;

   localparam logic [12:0] PIXEL_COUNT_RST = 13'd4096;
   localparam logic [15:0] SCALE_K_RST     = 16'd38400;
   localparam logic [12:0] MIN_SIZE_RST    = 13'd1;

   typedef enum logic [1:0] {
      ACT_CLEAR   = 2'd0,
      ACT_LOAD    = 2'd1,
      ACT_SEGMENT = 2'd2,
      ACT_QUERY   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_FULL  = 2'd1,
      STS_RANGE = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      CSR_PIXEL_COUNT = 2'd0,
      CSR_SCALE_K     = 2'd1,
      CSR_MIN_SIZE    = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_INIT,
      ST_IDLE,
      ST_SORT_RUN,
      ST_SORT_FILL,
      ST_SORT_LDI,
      ST_SORT_LDJ,
      ST_SORT_EMIT,
      ST_PASS_NEXT,
      ST_EDGE_CHK,
      ST_FA_RD,
      ST_FA_CHK,
      ST_FB_RD,
      ST_FB_CHK,
      ST_DECIDE,
      ST_DIV,
      ST_WR_LOSE,
      ST_WR_WIN
   } state_type;

   typedef struct packed {
      action_type                   action;
      logic [PIX_FIELD_W-1:0]       pixel_a;
      logic [PIX_FIELD_W-1:0]       pixel_b;
      logic [WEIGHT_W-1:0]          weight;
   } req_type;

   typedef struct packed {
      status_type                   status;
      logic                         same_component;
      logic [SIZE_FIELD_W-1:0]      component_size;
   } rsp_type;

   // one stored edge
   typedef struct packed {
      logic [PIX_FIELD_W-1:0]       pixel_a;
      logic [PIX_FIELD_W-1:0]       pixel_b;
      logic [WEIGHT_W-1:0]          weight;
   } edge_type;

   localparam int EDGE_W = $bits(edge_type);

endpackage

// ===== rtl/core/gms_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
module gms_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/gms_div.sv =====
// Restoring divider, one quotient bit per cycle.
module gms_div #(
   parameter int DW = 16,
   parameter int VW = 13
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [VW-1:0] divisor,
   output logic          done,
   output logic [DW-1:0] quotient
);

   localparam int CNT_W = $clog2(DW + 1);

   logic [VW:0]      rem_ff, rem_in;
   logic [DW-1:0]    quo_ff, quo_in;
   logic [VW-1:0]    dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [VW:0]      shifted;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff[VW-1:0], quo_ff[DW-1]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, dvs_ff}) begin
            rem_in = shifted - {1'b0, dvs_ff};
            quo_in = {quo_ff[DW-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[DW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== rtl/core/graph_merge_segmenter_core.sv =====
// Top level of the graph merge segmenter: edge store, sorter and union-find engine.
//
// Greedy graph segmentation over a loaded edge list. Clear and load are
// handled in the idle state, so edges stream in one per cycle while the skid
// register is empty. A query walks both trees of the union-find memory, one
// read per hop (single read port, registered read). A segment runs a forest
// init over n entries, then a bottom-up merge sort across edge banks 0 and 1
// (ceil(log2 E) levels), then two passes over the edges, each edge walking
// both trees and making 2 writes on a merge, with the k/size divider run in
// pass one. A stale edge is skipped without a tree walk. After reset the
// union-find memory is swept over all MAX_PIXELS entries before the first
// transfer on the request side is taken; the CSR port is always ready. One
// result sits in rsp_ and one in a skid register, so a new request is taken
// while a result waits.
module graph_merge_segmenter_core #(
   parameter int MAX_PIXELS = gms_pkg::MAX_PIXELS_DEF,
   parameter int MAX_EDGES  = gms_pkg::MAX_EDGES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  gms_pkg::req_type                req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output gms_pkg::rsp_type                rsp_data,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [1:0]                      csr_index,
   input  logic [gms_pkg::CSR_DATA_W-1:0]  csr_wdata
);

`include "graph_merge_segmenter_core_defines.svh"

   localparam int PW   = $clog2(MAX_PIXELS);      // pixel index
   localparam int SW   = $clog2(MAX_PIXELS + 1);  // set size
   localparam int TW   = gms_pkg::THR_W;
   localparam int UW   = PW + SW + TW;            // union-find entry
   localparam int EAW  = $clog2(MAX_EDGES);
   localparam int ECW  = $clog2(MAX_EDGES + 1);
   localparam int SRW  = ECW + 2;                 // sort run bounds
   localparam int CW   = gms_pkg::CMP_W;
   localparam int EW   = gms_pkg::EDGE_W;

   // ---------------- state and registers
   gms_pkg::state_type state_ff, state_in;
   logic [12:0]    pixel_count_ff;
   logic [15:0]    scale_k_ff;
   logic [12:0]    min_size_ff;
   logic [ECW-1:0] edge_count_ff, edge_count_in;
   logic           cur_bank_ff, cur_bank_in;
   logic           src_ff, src_in;
   logic [SRW-1:0] width_ff, width_in, lo_ff, lo_in, mid_ff, mid_in, hi_ff, hi_in;
   logic [SRW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic           hvi_ff, hvi_in, hvj_ff, hvj_in;
   gms_pkg::edge_type head_i_ff, head_i_in, head_j_ff, head_j_in;
   logic           pass_ff, pass_in;
   logic [ECW-1:0] eidx_ff, eidx_in;
   gms_pkg::edge_type edge_ff, edge_in;
   logic [PW-1:0]  x_ff, x_in;
   logic [PW-1:0]  ra_ff, ra_in, rb_ff, rb_in;
   logic [SW-1:0]  sa_ff, sa_in, sb_ff, sb_in;
   logic [TW-1:0]  ta_ff, ta_in, tb_ff, tb_in;
   logic [PW-1:0]  win_ff, win_in, lose_ff, lose_in;
   logic [SW-1:0]  lsize_ff, lsize_in, nsize_ff, nsize_in;
   logic [TW-1:0]  lthr_ff, lthr_in, wthr_ff, wthr_in;
   logic           query_ff, query_in;
   logic [SW-1:0]  init_cnt_ff, init_cnt_in, init_end_ff, init_end_in;
   logic           init_seg_ff, init_seg_in;
   logic           rsp_valid_ff, skid_v_ff;
   gms_pkg::rsp_type rsp_data_ff, skid_data_ff;

   // ---------------- datapath signals
   logic              req_accept;
   logic              fin_v;
   gms_pkg::rsp_type  fin_data;
   logic [CW-1:0]     n_cmp;
   logic              e_we;
   logic              e_wbank;
   logic [EAW-1:0]    e_waddr, e_raddr;
   logic [EW-1:0]     e_wdata;
   logic [EW-1:0]     e_rdata0, e_rdata1;
   gms_pkg::edge_type e_rdata;
   logic              uf_we;
   logic [PW-1:0]     uf_waddr, uf_raddr;
   logic [UW-1:0]     uf_wdata, uf_rdata;
   logic [PW-1:0]     uf_parent;
   logic [SW-1:0]     uf_size;
   logic [TW-1:0]     uf_thr;
   logic              div_start, div_done;
   logic [15:0]       div_q;
   logic [SRW-1:0]    n_sort, lo_next, w2;
   logic              cond;

   // effective pixel count clamped to 1..MAX_PIXELS
   always_comb begin
      if (pixel_count_ff == 13'd0) begin
         n_cmp = CW'(1);
      end else if (CW'(pixel_count_ff) > CW'(MAX_PIXELS)) begin
         n_cmp = CW'(MAX_PIXELS);
      end else begin
         n_cmp = CW'(pixel_count_ff);
      end
   end

   assign e_rdata   = gms_pkg::edge_type'(src_ff ? e_rdata1 : e_rdata0);
   assign uf_parent = uf_rdata[UW-1 -: PW];
   assign uf_size   = uf_rdata[TW +: SW];
   assign uf_thr    = uf_rdata[TW-1:0];
   assign n_sort    = SRW'(edge_count_ff);
   assign lo_next   = lo_ff + (width_ff << 1);
   assign w2        = width_ff << 1;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = (state_ff != gms_pkg::ST_IDLE) || skid_v_ff;
   assign csr_ready  = 1'b1;

   // ---------------- memories: edge banks 0 and 1 (ping-pong sort) and the forest
   gms_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_bank0 (
      .clock (clock),
      .we    (e_we && !e_wbank),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata0)
   );

   gms_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_bank1 (
      .clock (clock),
      .we    (e_we && e_wbank),
      .waddr (e_waddr),
      .wdata (e_wdata),
      .raddr (e_raddr),
      .rdata (e_rdata1)
   );

   gms_ram #(.WIDTH(UW), .DEPTH(MAX_PIXELS)) u_forest (
      .clock (clock),
      .we    (uf_we),
      .waddr (uf_waddr),
      .wdata (uf_wdata),
      .raddr (uf_raddr),
      .rdata (uf_rdata)
   );

   // k / merged size for the new threshold; divisor is latched at start
   gms_div #(.DW(16), .VW(SW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (scale_k_ff),
      .divisor  (nsize_in),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- sequencer
   always_comb begin
      state_in      = state_ff;
      edge_count_in = edge_count_ff;
      cur_bank_in   = cur_bank_ff;
      src_in        = src_ff;
      width_in      = width_ff;
      lo_in         = lo_ff;
      mid_in        = mid_ff;
      hi_in         = hi_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      hvi_in        = hvi_ff;
      hvj_in        = hvj_ff;
      head_i_in     = head_i_ff;
      head_j_in     = head_j_ff;
      pass_in       = pass_ff;
      eidx_in       = eidx_ff;
      edge_in       = edge_ff;
      x_in          = x_ff;
      ra_in         = ra_ff;
      sa_in         = sa_ff;
      ta_in         = ta_ff;
      rb_in         = rb_ff;
      sb_in         = sb_ff;
      tb_in         = tb_ff;
      win_in        = win_ff;
      lose_in       = lose_ff;
      lsize_in      = lsize_ff;
      lthr_in       = lthr_ff;
      nsize_in      = nsize_ff;
      wthr_in       = wthr_ff;
      query_in      = query_ff;
      init_cnt_in   = init_cnt_ff;
      init_end_in   = init_end_ff;
      init_seg_in   = init_seg_ff;
      fin_v         = 1'b0;
      fin_data      = '{status: gms_pkg::STS_OK, same_component: 1'b0, component_size: '0};
      e_we          = 1'b0;
      e_wbank       = cur_bank_ff;
      e_waddr       = EAW'(edge_count_ff);
      e_wdata       = EW'(req_data.pixel_a) << (EW - gms_pkg::PIX_FIELD_W);
      e_raddr       = EAW'(eidx_ff);
      uf_we         = 1'b0;
      uf_waddr      = PW'(init_cnt_ff);
      uf_wdata      = {PW'(init_cnt_ff), SW'(1), TW'(scale_k_ff)};
      uf_raddr      = x_ff;
      div_start     = 1'b0;
      cond          = 1'b0;

      case (state_ff)
         // forest sweep: after reset over all entries, at segment over n
         gms_pkg::ST_INIT: begin
            uf_we       = 1'b1;
            init_cnt_in = init_cnt_ff + 1'b1;
            if (init_cnt_ff + 1'b1 == init_end_ff) begin
               if (init_seg_ff) begin
                  width_in = SRW'(1);
                  lo_in    = '0;
                  src_in   = cur_bank_ff;
                  if (n_sort <= SRW'(1)) begin
                     pass_in  = 1'b0;
                     eidx_in  = '0;
                     state_in = gms_pkg::ST_PASS_NEXT;
                  end else begin
                     state_in = gms_pkg::ST_SORT_RUN;
                  end
               end else begin
                  state_in = gms_pkg::ST_IDLE;
               end
            end
         end

         gms_pkg::ST_IDLE: begin
            if (req_accept) begin
               edge_in = '{pixel_a: req_data.pixel_a, pixel_b: req_data.pixel_b,
                           weight: req_data.weight};
               case (req_data.action)
                  gms_pkg::ACT_CLEAR: begin
                     edge_count_in = '0;
                     fin_v         = 1'b1;
                  end
                  gms_pkg::ACT_LOAD: begin
                     fin_v = 1'b1;
                     if (CW'(req_data.pixel_a) >= n_cmp || CW'(req_data.pixel_b) >= n_cmp) begin
                        fin_data.status = gms_pkg::STS_RANGE;
                     end else if (edge_count_ff == ECW'(MAX_EDGES)) begin
                        fin_data.status = gms_pkg::STS_FULL;
                     end else begin
                        e_we          = 1'b1;
                        e_wdata       = {req_data.pixel_a, req_data.pixel_b, req_data.weight};
                        edge_count_in = edge_count_ff + 1'b1;
                     end
                  end
                  gms_pkg::ACT_SEGMENT: begin
                     init_cnt_in = '0;
                     init_end_in = SW'(n_cmp);
                     init_seg_in = 1'b1;
                     query_in    = 1'b0;
                     state_in    = gms_pkg::ST_INIT;
                  end
                  gms_pkg::ACT_QUERY: begin
                     if (CW'(req_data.pixel_a) >= n_cmp || CW'(req_data.pixel_b) >= n_cmp) begin
                        fin_v           = 1'b1;
                        fin_data.status = gms_pkg::STS_RANGE;
                     end else begin
                        query_in = 1'b1;
                        x_in     = PW'(req_data.pixel_a);
                        state_in = gms_pkg::ST_FA_RD;
                     end
                  end
                  default: begin
                     fin_v = 1'b1;
                  end
               endcase
            end
         end

         // ---- merge sort: one run per visit, heads held in registers
         gms_pkg::ST_SORT_RUN: begin
            mid_in   = (lo_ff + width_ff > n_sort) ? n_sort : lo_ff + width_ff;
            hi_in    = (lo_next > n_sort) ? n_sort : lo_next;
            i_in     = lo_ff;
            j_in     = (lo_ff + width_ff > n_sort) ? n_sort : lo_ff + width_ff;
            k_in     = lo_ff;
            hvi_in   = 1'b0;
            hvj_in   = 1'b0;
            state_in = gms_pkg::ST_SORT_FILL;
         end

         gms_pkg::ST_SORT_FILL: begin
            if (!hvi_ff && i_ff < mid_ff) begin
               e_raddr  = EAW'(i_ff);
               state_in = gms_pkg::ST_SORT_LDI;
            end else if (!hvj_ff && j_ff < hi_ff) begin
               e_raddr  = EAW'(j_ff);
               state_in = gms_pkg::ST_SORT_LDJ;
            end else begin
               state_in = gms_pkg::ST_SORT_EMIT;
            end
         end

         gms_pkg::ST_SORT_LDI: begin
            head_i_in = e_rdata;
            hvi_in    = 1'b1;
            i_in      = i_ff + 1'b1;
            state_in  = gms_pkg::ST_SORT_FILL;
         end

         gms_pkg::ST_SORT_LDJ: begin
            head_j_in = e_rdata;
            hvj_in    = 1'b1;
            j_in      = j_ff + 1'b1;
            state_in  = gms_pkg::ST_SORT_FILL;
         end

         gms_pkg::ST_SORT_EMIT: begin
            e_wbank  = !src_ff;
            e_waddr  = EAW'(k_ff);
            state_in = gms_pkg::ST_SORT_FILL;
            // right head wins only when strictly lighter: keeps ties stable
            if (hvi_ff && hvj_ff && head_j_ff.weight < head_i_ff.weight) begin
               e_we    = 1'b1;
               e_wdata = head_j_ff;
               hvj_in  = 1'b0;
               k_in    = k_ff + 1'b1;
            end else if (hvi_ff) begin
               e_we    = 1'b1;
               e_wdata = head_i_ff;
               hvi_in  = 1'b0;
               k_in    = k_ff + 1'b1;
            end else if (hvj_ff) begin
               e_we    = 1'b1;
               e_wdata = head_j_ff;
               hvj_in  = 1'b0;
               k_in    = k_ff + 1'b1;
            end else if (lo_next >= n_sort) begin
               width_in = w2;
               src_in   = !src_ff;
               lo_in    = '0;
               if (w2 >= n_sort) begin
                  cur_bank_in = !src_ff;
                  pass_in     = 1'b0;
                  eidx_in     = '0;
                  state_in    = gms_pkg::ST_PASS_NEXT;
               end else begin
                  state_in = gms_pkg::ST_SORT_RUN;
               end
            end else begin
               lo_in    = lo_next;
               state_in = gms_pkg::ST_SORT_RUN;
            end
         end

         // ---- merge passes over the sorted edges
         gms_pkg::ST_PASS_NEXT: begin
            e_raddr = EAW'(eidx_ff);
            if (eidx_ff == edge_count_ff) begin
               if (!pass_ff) begin
                  pass_in = 1'b1;
                  eidx_in = '0;
               end else begin
                  fin_v    = 1'b1;
                  state_in = gms_pkg::ST_IDLE;
               end
            end else begin
               state_in = gms_pkg::ST_EDGE_CHK;
            end
         end

         gms_pkg::ST_EDGE_CHK: begin
            edge_in = gms_pkg::edge_type'(cur_bank_ff ? e_rdata1 : e_rdata0);
            // stale edge: endpoint beyond current pixel count
            if (CW'(edge_in.pixel_a) >= n_cmp || CW'(edge_in.pixel_b) >= n_cmp) begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = gms_pkg::ST_PASS_NEXT;
            end else begin
               x_in     = PW'(edge_in.pixel_a);
               state_in = gms_pkg::ST_FA_RD;
            end
         end

         gms_pkg::ST_FA_RD: begin
            uf_raddr = x_ff;
            state_in = gms_pkg::ST_FA_CHK;
         end

         gms_pkg::ST_FA_CHK: begin
            if (uf_parent == x_ff) begin
               ra_in    = x_ff;
               sa_in    = uf_size;
               ta_in    = uf_thr;
               x_in     = PW'(edge_ff.pixel_b);
               state_in = gms_pkg::ST_FB_RD;
            end else begin
               x_in     = uf_parent;
               state_in = gms_pkg::ST_FA_RD;
            end
         end

         gms_pkg::ST_FB_RD: begin
            uf_raddr = x_ff;
            state_in = gms_pkg::ST_FB_CHK;
         end

         gms_pkg::ST_FB_CHK: begin
            if (uf_parent == x_ff) begin
               rb_in = x_ff;
               sb_in = uf_size;
               tb_in = uf_thr;
               if (query_ff) begin
                  fin_v                   = 1'b1;
                  fin_data.same_component = (ra_ff == x_ff);
                  fin_data.component_size = gms_pkg::SIZE_FIELD_W'(sa_ff);
                  state_in                = gms_pkg::ST_IDLE;
               end else begin
                  state_in = gms_pkg::ST_DECIDE;
               end
            end else begin
               x_in     = uf_parent;
               state_in = gms_pkg::ST_FB_RD;
            end
         end

         gms_pkg::ST_DECIDE: begin
            if (!pass_ff) begin
               cond = (TW'(edge_ff.weight) <= ta_ff) && (TW'(edge_ff.weight) <= tb_ff);
            end else begin
               cond = (CW'(sa_ff) < CW'(min_size_ff)) || (CW'(sb_ff) < CW'(min_size_ff));
            end
            nsize_in = sa_ff + sb_ff;
            // larger set keeps its root; a tie keeps pixel_a's root
            if (sa_ff < sb_ff) begin
               win_in   = rb_ff;
               wthr_in  = tb_ff;
               lose_in  = ra_ff;
               lsize_in = sa_ff;
               lthr_in  = ta_ff;
            end else begin
               win_in   = ra_ff;
               wthr_in  = ta_ff;
               lose_in  = rb_ff;
               lsize_in = sb_ff;
               lthr_in  = tb_ff;
            end
            if (ra_ff != rb_ff && cond) begin
               state_in = pass_ff ? gms_pkg::ST_WR_LOSE : gms_pkg::ST_DIV;
               div_start = !pass_ff;
            end else begin
               eidx_in  = eidx_ff + 1'b1;
               state_in = gms_pkg::ST_PASS_NEXT;
            end
         end

         gms_pkg::ST_DIV: begin
            if (div_done) begin
               // 16 + 16 bits fit in 17 with no overflow, so no clamp is hit
               wthr_in  = TW'(edge_ff.weight) + TW'(div_q);
               state_in = gms_pkg::ST_WR_LOSE;
            end
         end

         gms_pkg::ST_WR_LOSE: begin
            uf_we    = 1'b1;
            uf_waddr = lose_ff;
            uf_wdata = {win_ff, lsize_ff, lthr_ff};
            state_in = gms_pkg::ST_WR_WIN;
         end

         gms_pkg::ST_WR_WIN: begin
            uf_we    = 1'b1;
            uf_waddr = win_ff;
            uf_wdata = {win_ff, nsize_ff, wthr_ff};
            eidx_in  = eidx_ff + 1'b1;
            state_in = gms_pkg::ST_PASS_NEXT;
         end

         default: begin
            state_in = gms_pkg::ST_IDLE;
         end
      endcase
   end

   // ---------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= gms_pkg::ST_INIT;
         init_cnt_ff    <= '0;
         init_end_ff    <= SW'(MAX_PIXELS);
         init_seg_ff    <= 1'b0;
         pixel_count_ff <= gms_pkg::PIXEL_COUNT_RST;
         scale_k_ff     <= gms_pkg::SCALE_K_RST;
         min_size_ff    <= gms_pkg::MIN_SIZE_RST;
         edge_count_ff  <= '0;
         cur_bank_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         skid_v_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         init_cnt_ff   <= init_cnt_in;
         init_end_ff   <= init_end_in;
         init_seg_ff   <= init_seg_in;
         edge_count_ff <= edge_count_in;
         cur_bank_ff   <= cur_bank_in;
         if (csr_valid && csr_ready) begin
            case (csr_index)
               gms_pkg::CSR_PIXEL_COUNT: pixel_count_ff <= csr_wdata[12:0];
               gms_pkg::CSR_SCALE_K:     scale_k_ff     <= csr_wdata;
               gms_pkg::CSR_MIN_SIZE:    min_size_ff    <= csr_wdata[12:0];
               default: ;
            endcase
         end
         // output register with one skid slot behind it
         if (!rsp_valid_ff || !rsp_stall) begin
            if (skid_v_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= skid_data_ff;
               skid_v_ff    <= fin_v;
               skid_data_ff <= fin_data;
            end else begin
               rsp_valid_ff <= fin_v;
               rsp_data_ff  <= fin_data;
            end
         end else if (fin_v) begin
            skid_v_ff    <= 1'b1;
            skid_data_ff <= fin_data;
         end
      end
      src_ff    <= src_in;
      width_ff  <= width_in;
      lo_ff     <= lo_in;
      mid_ff    <= mid_in;
      hi_ff     <= hi_in;
      i_ff      <= i_in;
      j_ff      <= j_in;
      k_ff      <= k_in;
      hvi_ff    <= hvi_in;
      hvj_ff    <= hvj_in;
      head_i_ff <= head_i_in;
      head_j_ff <= head_j_in;
      pass_ff   <= pass_in;
      eidx_ff   <= eidx_in;
      edge_ff   <= edge_in;
      x_ff      <= x_in;
      ra_ff     <= ra_in;
      sa_ff     <= sa_in;
      ta_ff     <= ta_in;
      rb_ff     <= rb_in;
      sb_ff     <= sb_in;
      tb_ff     <= tb_in;
      win_ff    <= win_in;
      lose_ff   <= lose_in;
      lsize_ff  <= lsize_in;
      lthr_ff   <= lthr_in;
      nsize_ff  <= nsize_in;
      wthr_ff   <= wthr_in;
      query_ff  <= query_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------- checks
   `GMS_ASSERT_IMPLY(a_accept_idle, req_accept, (state_ff == gms_pkg::ST_IDLE) && !skid_v_ff, "busy")
   `GMS_ASSERT_ALWAYS(a_count_bound, edge_count_ff <= ECW'(MAX_EDGES), "edge count past store depth")
   `GMS_ASSERT_IMPLY(a_skid_order, skid_v_ff, rsp_valid_ff, "skid holds a result with empty output")
   `GMS_ASSERT_IMPLY(a_div_owner, div_done, state_ff == gms_pkg::ST_DIV, "divider finished outside merge")

endmodule

// ===== tb/sv/graph_merge_segmenter_core_test.sv =====
// Self-checking testbench for the graph merge segmenter core.
module graph_merge_segmenter_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   // Union-find segmentation predictor plus the queue of expected responses.
   class segmenter_scoreboard;
      logic [11:0] parent[4096];
      int unsigned set_sz[4096];
      int unsigned seg_thr[4096];
      gms_pkg::edge_type edges[8192];
      gms_pkg::edge_type scratch[8192];
      int unsigned n_edges;
      int unsigned pix_cnt, k_val, min_sz;
      gms_pkg::rsp_type expected_q[$];
      int          errors;
      int          segments, queries, fulls, ranges;

      function new();
         pix_cnt = gms_pkg::PIXEL_COUNT_RST;
         k_val   = gms_pkg::SCALE_K_RST;
         min_sz  = gms_pkg::MIN_SIZE_RST;
         n_edges = 0;
         for (int i = 0; i < 4096; i++) begin
            parent[i]  = 12'(i);
            set_sz[i]  = 1;
            seg_thr[i] = k_val;
         end
      endfunction

      function void write_reg(gms_pkg::csr_index_type idx, logic [15:0] val);
         case (idx)
            gms_pkg::CSR_PIXEL_COUNT: pix_cnt = val & 16'h1FFF;
            gms_pkg::CSR_SCALE_K:     k_val   = val;
            gms_pkg::CSR_MIN_SIZE:    min_sz  = val & 16'h1FFF;
            default: ;
         endcase
      endfunction

      function int unsigned active_n();
         if (pix_cnt < 1) return 1;
         if (pix_cnt > 4096) return 4096;
         return pix_cnt;
      endfunction

      function int unsigned root_of(int unsigned x);
         while (parent[x] != x) x = parent[x];
         return x;
      endfunction

      // larger set keeps its root
      function int unsigned join_sets(int unsigned ra, int unsigned rb);
         int unsigned t;
         if (set_sz[ra] < set_sz[rb]) begin
            t = ra; ra = rb; rb = t;
         end
         parent[rb] = 12'(ra);
         set_sz[ra] += set_sz[rb];
         return ra;
      endfunction

      // bottom-up merge sort, ties keep load order
      function void sort_by_weight();
         int unsigned w2, lo, mid, hi, i, j, o;
         for (w2 = 1; w2 < n_edges; w2 *= 2) begin
            for (lo = 0; lo < n_edges; lo += 2 * w2) begin
               mid = (lo + w2 > n_edges) ? n_edges : lo + w2;
               hi  = (lo + 2 * w2 > n_edges) ? n_edges : lo + 2 * w2;
               i = lo; j = mid; o = lo;
               while (i < mid && j < hi) begin
                  if (edges[j].weight < edges[i].weight) scratch[o++] = edges[j++];
                  else scratch[o++] = edges[i++];
               end
               while (i < mid) scratch[o++] = edges[i++];
               while (j < hi) scratch[o++] = edges[j++];
            end
            for (i = 0; i < n_edges; i++) edges[i] = scratch[i];
         end
      endfunction

      function void run_segmentation();
         int unsigned n, ra, rb, r, thr;
         n = active_n();
         for (int unsigned i = 0; i < n; i++) begin
            parent[i]  = 12'(i);
            set_sz[i]  = 1;
            seg_thr[i] = k_val;
         end
         sort_by_weight();
         for (int unsigned i = 0; i < n_edges; i++) begin
            if (edges[i].pixel_a >= n || edges[i].pixel_b >= n) continue;
            ra = root_of(edges[i].pixel_a);
            rb = root_of(edges[i].pixel_b);
            if (ra == rb) continue;
            if (edges[i].weight <= seg_thr[ra] && edges[i].weight <= seg_thr[rb]) begin
               r = join_sets(ra, rb);
               thr = edges[i].weight + k_val / set_sz[r];
               seg_thr[r] = (thr > 131071) ? 131071 : thr;
            end
         end
         // small-component cleanup
         for (int unsigned i = 0; i < n_edges; i++) begin
            if (edges[i].pixel_a >= n || edges[i].pixel_b >= n) continue;
            ra = root_of(edges[i].pixel_a);
            rb = root_of(edges[i].pixel_b);
            if (ra != rb && (set_sz[ra] < min_sz || set_sz[rb] < min_sz))
               r = join_sets(ra, rb);
         end
      endfunction

      function void note_request(gms_pkg::req_type r);
         gms_pkg::rsp_type e;
         int unsigned n, ra, rb;
         n = active_n();
         e = '0;
         e.status = gms_pkg::STS_OK;
         case (r.action)
            gms_pkg::ACT_CLEAR: n_edges = 0;
            gms_pkg::ACT_LOAD: begin
               if (r.pixel_a >= n || r.pixel_b >= n) begin
                  e.status = gms_pkg::STS_RANGE; ranges++;
               end else if (n_edges >= 8192) begin
                  e.status = gms_pkg::STS_FULL; fulls++;
               end else begin
                  edges[n_edges].pixel_a = r.pixel_a;
                  edges[n_edges].pixel_b = r.pixel_b;
                  edges[n_edges].weight  = r.weight;
                  n_edges++;
               end
            end
            gms_pkg::ACT_SEGMENT: begin
               run_segmentation();
               segments++;
            end
            default: begin
               queries++;
               if (r.pixel_a >= n || r.pixel_b >= n) begin
                  e.status = gms_pkg::STS_RANGE; ranges++;
               end else begin
                  ra = root_of(r.pixel_a);
                  rb = root_of(r.pixel_b);
                  e.same_component = (ra == rb);
                  e.component_size = 13'(set_sz[ra]);
               end
            end
         endcase
         expected_q = {expected_q, e};
      endfunction

      task report(string what, int got, int want);
         $display("mismatch %s: got %0d, want %0d", what, got, want);
         errors++;
      endtask

      task check_response(gms_pkg::rsp_type got);
         gms_pkg::rsp_type want;
         if (expected_q.size() == 0) begin
            report("unexpected transfer, status", got.status, -1);
            return;
         end
         want = expected_q.pop_front();
         if (got.status !== want.status) report("status", got.status, want.status);
         if (got.same_component !== want.same_component)
            report("same_component", got.same_component, want.same_component);
         if (got.component_size !== want.component_size)
            report("component_size", got.component_size, want.component_size);
      endtask
   endclass

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   gms_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   gms_pkg::rsp_type rsp_data;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [1:0]       csr_index = '0;
   logic [15:0]      csr_wdata = '0;

   segmenter_scoreboard sb = new();

   bit          quiet;          // no idling on either side
   bit          hold_req;       // asks the receiver for a long stall
   int          hold_cnt;
   int          sent;
   longint      cycles;

   graph_merge_segmenter_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // watchdog: well above the slowest legal run, including the init sweep
   always @(posedge clock) begin
      cycles++;
      if (cycles > 4000000) begin
         $display("timeout after %0d cycles", cycles);
         $display("status: fail");
         $finish;
      end
   end

   // response side: random stalls, or a long hold-off when asked
   always @(negedge clock) begin
      if (hold_req) begin
         hold_cnt = 400;
         hold_req = 1'b0;
      end
      if (hold_cnt > 0) begin
         hold_cnt--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 18);
      end
   end

   // every accepted response transfer is checked at the edge that takes it
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) sb.check_response(rsp_data);
   end

   // one request transfer; valid stays high on return so back-to-back items
   // never see a lower-then-raise inside one time step
   task automatic push_req(gms_pkg::action_type a, int unsigned pa, int unsigned pb,
                           int unsigned w);
      gms_pkg::req_type r;
      r.action  = a;
      r.pixel_a = 12'(pa);
      r.pixel_b = 12'(pb);
      r.weight  = 16'(w);
      if (!quiet && $urandom_range(99) < 18) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(r);
      sent++;
      @(negedge clock);
   endtask

   // drop valid and wait until every expected transfer has come back
   task automatic drain();
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   // only called while the core is idle
   task automatic write_csr(gms_pkg::csr_index_type idx, int unsigned val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(val);
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, 16'(val));
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // mostly a small cluster of pixels so components actually form
   function automatic int unsigned pick_pixel(int unsigned n);
      if ($urandom_range(3) == 0) return $urandom_range(0, n - 1);
      return $urandom_range(0, ((n < 24) ? n : 24) - 1);
   endfunction

   function automatic int unsigned pick_weight(int unsigned k);
      case ($urandom_range(3))
         0: return $urandom_range(0, 65535);
         1: return $urandom_range(0, 3) * 64;     // plenty of ties
         default: return $urandom_range(0, k);
      endcase
   endfunction

   task automatic random_phase(int unsigned n_load, int unsigned n_query);
      int unsigned n;
      n = sb.active_n();
      if ($urandom_range(4) != 0) push_req(gms_pkg::ACT_CLEAR, $urandom, $urandom, $urandom);
      for (int i = 0; i < n_load; i++) begin
         if ($urandom_range(19) == 0)
            push_req(gms_pkg::action_type'(2'($urandom_range(3))), $urandom, $urandom,
                     $urandom);
         else if ($urandom_range(14) == 0)
            push_req(gms_pkg::ACT_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom);
         else
            push_req(gms_pkg::ACT_LOAD, pick_pixel(n), pick_pixel(n), pick_weight(sb.k_val));
      end
      push_req(gms_pkg::ACT_SEGMENT, $urandom, $urandom, $urandom);
      for (int i = 0; i < n_query; i++) begin
         if ($urandom_range(9) == 0)
            push_req(gms_pkg::ACT_QUERY, $urandom_range(0, 4095), $urandom_range(0, 4095),
                     $urandom);
         else
            push_req(gms_pkg::ACT_QUERY, pick_pixel(n), pick_pixel(n), $urandom);
      end
   endtask

   initial begin
      int unsigned rand_items, pc, kk, ms;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: queries on the reset forest, full pixel range
      push_req(gms_pkg::ACT_QUERY, 0, 4095, 0);
      push_req(gms_pkg::ACT_QUERY, 4095, 4095, 16'hFFFF);
      drain();
      write_csr(gms_pkg::CSR_PIXEL_COUNT, 16);
      write_csr(gms_pkg::CSR_SCALE_K, 128);
      write_csr(gms_pkg::CSR_MIN_SIZE, 1);
      push_req(gms_pkg::ACT_CLEAR, 0, 0, 0);
      push_req(gms_pkg::ACT_LOAD, 0, 15, 0);
      push_req(gms_pkg::ACT_LOAD, 15, 1, 65535);
      push_req(gms_pkg::ACT_LOAD, 3, 4, 100);
      push_req(gms_pkg::ACT_LOAD, 4, 5, 100);       // tie with the previous load
      push_req(gms_pkg::ACT_LOAD, 6, 6, 10);        // self loop
      push_req(gms_pkg::ACT_LOAD, 16, 0, 5);        // endpoint out of range
      push_req(gms_pkg::ACT_LOAD, 0, 4095, 5);
      push_req(gms_pkg::ACT_SEGMENT, 0, 0, 0);
      push_req(gms_pkg::ACT_QUERY, 0, 15, 0);
      push_req(gms_pkg::ACT_QUERY, 3, 5, 0);
      push_req(gms_pkg::ACT_QUERY, 7, 7, 0);
      push_req(gms_pkg::ACT_QUERY, 2, 16, 0);       // query out of range
      drain();
      // same edges, max k and a min-size cleanup
      write_csr(gms_pkg::CSR_SCALE_K, 65535);
      write_csr(gms_pkg::CSR_MIN_SIZE, 4);
      push_req(gms_pkg::ACT_SEGMENT, 0, 0, 0);
      push_req(gms_pkg::ACT_QUERY, 15, 3, 0);
      push_req(gms_pkg::ACT_QUERY, 9, 10, 0);
      drain();
      // shrink n: stored edges beyond it go stale, pixels past it keep forest
      write_csr(gms_pkg::CSR_PIXEL_COUNT, 4);
      push_req(gms_pkg::ACT_SEGMENT, 0, 0, 0);
      push_req(gms_pkg::ACT_QUERY, 3, 3, 0);
      push_req(gms_pkg::ACT_QUERY, 3, 9, 0);
      drain();
      write_csr(gms_pkg::CSR_PIXEL_COUNT, 16);
      push_req(gms_pkg::ACT_QUERY, 4, 5, 0);
      push_req(gms_pkg::ACT_QUERY, 15, 0, 0);
      drain();

      // random phases; the first stretch runs without idling
      rand_items = 0;
      while (rand_items < 800) begin
         quiet = (rand_items < 160);
         drain();
         case ($urandom_range(7))
            0: pc = 1;
            1: pc = 4096;
            2: pc = 0;
            3: pc = 8191;
            4: pc = $urandom_range(2, 8);
            default: pc = $urandom_range(9, 200);
         endcase
         case ($urandom_range(3))
            0: kk = 128;
            1: kk = 65535;
            default: kk = $urandom_range(128, 65535);
         endcase
         case ($urandom_range(4))
            0: ms = 0;
            1: ms = 1;
            2: ms = 4096;
            default: ms = $urandom_range(2, 12);
         endcase
         write_csr(gms_pkg::CSR_PIXEL_COUNT, pc);
         write_csr(gms_pkg::CSR_SCALE_K, kk);
         write_csr(gms_pkg::CSR_MIN_SIZE, ms);
         pc = sent;
         random_phase($urandom_range(0, 40), $urandom_range(4, 16));
         rand_items += sent - pc;

         if (rand_items > 300 && rand_items < 380) begin
            // back-pressure: receiver holds off while loads keep coming
            drain();
            hold_req = 1'b1;
            for (int i = 0; i < 40; i++)
               push_req(gms_pkg::ACT_LOAD, pick_pixel(sb.active_n()),
                        pick_pixel(sb.active_n()), pick_weight(sb.k_val));
            drain();                        // sender pauses for all transfers
            rand_items += 40;
         end
      end

      // full pixel range: a few wide edges, then a tiny segment
      drain();
      quiet = 1'b1;
      write_csr(gms_pkg::CSR_PIXEL_COUNT, 4096);
      push_req(gms_pkg::ACT_CLEAR, 0, 0, 0);
      for (int i = 0; i < 12; i++)
         push_req(gms_pkg::ACT_LOAD, $urandom_range(0, 4095), $urandom_range(0, 4095),
                  $urandom);
      push_req(gms_pkg::ACT_LOAD, 1, 4095, 3);
      push_req(gms_pkg::ACT_SEGMENT, 0, 0, 0);
      push_req(gms_pkg::ACT_QUERY, 1, 4095, 0);
      push_req(gms_pkg::ACT_CLEAR, 0, 0, 0);
      push_req(gms_pkg::ACT_LOAD, 2, 3, 1);
      push_req(gms_pkg::ACT_SEGMENT, 0, 0, 0);
      push_req(gms_pkg::ACT_QUERY, 3, 2, 0);
      quiet = 1'b0;

      drain();
      repeat (200) @(posedge clock);
      $display("covered %0d transfers: %0d segments, %0d queries", sent, sb.segments, sb.queries);
      $display("store-full hits %0d, range errors %0d, mismatches %0d",
               sb.fulls, sb.ranges, sb.errors);
      if (sb.errors == 0 && sb.expected_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/gms_pkg.sv
rtl/core/gms_ram.sv
rtl/core/gms_div.sv
rtl/core/graph_merge_segmenter_core.sv
tb/sv/graph_merge_segmenter_core_test.sv
